>>> rtl/gpc_pkg.sv
// Shared constants and register codes for the 3x3 grid peak counter.
// No dependencies; imported by the top level.
`default_nettype none

package gpc_pkg;

  // Parameter defaults.
  localparam int MAX_COLS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 11;
  localparam int ROW_CNT_W  = 12;
  localparam int COUNT_W    = 21;
  localparam int ROWS_LIMIT = 4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/gpc_line_store.sv
// Line store memory for the peak counter: upper and middle rows in one word.
// One write port and one registered read port; no package dependency.
`default_nettype none

module gpc_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read returns the contents before any write in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gpc_column_cell.sv
// One window column cell: holds three samples and compares them to the centre.
// Cells are chained; no package dependency.
`default_nettype none

module gpc_column_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           shift,
  input  wire logic [2:0][SAMPLE_WIDTH-1:0]   col_in,
  input  wire logic        [SAMPLE_WIDTH-1:0] centre,
  output logic      [2:0][SAMPLE_WIDTH-1:0]   col_q,
  output logic      [2:0]                     below
);

  // Element 0 is the top row of the window, element 2 the bottom row.
  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      below[k] = $signed(col_q[k]) < $signed(centre);
    end
  end

endmodule

`default_nettype wire

>>> rtl/grid_peak_counter_3x3_unit.sv
// Top level of the 3x3 grid peak counter.
// Uses gpc_pkg, gpc_line_store and gpc_column_cell.
`default_nettype none

// Elevation samples arrive in raster order, one request per sample, for a
// grid of grid_rows by grid_cols cells. Every sample yields exactly one
// result. A result flags whether the interior cell one row up and one
// column left of the sample is strictly higher than its eight neighbors,
// and carries the running peak count of the frame, which saturates and is
// cleared by the first sample of each frame. Border cells never count.
// The block takes one sample per clock while results are taken. A result
// passes through the read stage and then the output register. The stage
// that reads the line store and the output register both advance whenever
// the output is free or being taken, so one waiting result does not stop
// the next request; a request is held off only when a result waits and the
// read stage is full as well, or a register write is pending. The line
// store has one read port, used by the sample being taken, and one write
// port, used by the sample moving to the output.
// Writing either configuration register restarts the frame; a write to an
// index past the register list is ignored. Writes are taken only while no
// request is in flight, and a pending write holds off new requests.
// Register values of zero act as one, and values above the limits act as
// the limits (4096 rows, MAX_COLS columns). The line store needs no clearing
// after reset: an entry is only used once it was written in the same frame.
module grid_peak_counter_3x3_unit #(
  parameter int MAX_COLS     = gpc_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_WIDTH = gpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Sample channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    elevation,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   window_valid,
  output logic                                   is_peak,
  output logic        [gpc_pkg::COUNT_W-1:0]     peak_count,
  output logic                                   frame_last,
  // Configuration channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic   [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic   [gpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import gpc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_COLS);
  localparam int ECOL_W = CNT_W + 1;
  localparam int SW     = SAMPLE_WIDTH;

  // Configuration registers and their effective values.
  logic [ROWS_W-1:0] grid_rows;
  logic [COLS_W-1:0] grid_cols;
  logic [ROWS_W-1:0] rows_eff;
  logic [ECOL_W-1:0] cols_eff;
  logic              cfg_write;
  logic              cfg_restart;

  // Raster position.
  logic [ROW_CNT_W-1:0] row_cnt;
  logic [ROW_CNT_W-1:0] row_next;
  logic [CNT_W-1:0]     col_cnt;
  logic [CNT_W-1:0]     col_next;
  logic [ROW_CNT_W-1:0] r_cur;
  logic [CNT_W-1:0]     c_cur;
  logic [ROWS_W-1:0]    r_inc;
  logic [ECOL_W-1:0]    c_inc;

  // Read stage: sample taken, line store read issued.
  logic                 accept;
  logic                 advance;
  logic                 s1_valid;
  logic [SW-1:0]        s1_x;
  logic [CNT_W-1:0]     s1_idx;
  logic                 s1_first;
  logic                 s1_win;
  logic                 s1_last;
  logic [2*SW-1:0]      rd_word;
  logic [SW-1:0]        rd_upper;
  logic [SW-1:0]        rd_mid;

  // Window chain and compare.
  logic [2:0][SW-1:0]   new_col;
  logic [2:0][SW-1:0]   col_a;
  logic [2:0][SW-1:0]   col_b;
  logic [2:0]           below_a;
  logic [2:0]           below_b;
  logic [2:0]           below_new;
  logic [SW-1:0]        centre;
  logic                 peak;

  logic [COUNT_W-1:0]   peak_total;
  logic [COUNT_W-1:0]   peak_total_next;

  // A write waits until the read stage and the output register are empty,
  // so no result in flight ever sees its frame restarted.
  assign cfg_ready   = !s1_valid && !out_valid;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_write && (cfg_index inside {REG_GRID_ROWS, REG_GRID_COLS});

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= ROWS_W'(3);
      grid_cols <= COLS_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data[ROWS_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (32'(grid_rows) > 32'(ROWS_LIMIT)) begin
      rows_eff = ROWS_W'(ROWS_LIMIT);
    end else begin
      rows_eff = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_eff = ECOL_W'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_eff = ECOL_W'(MAX_COLS);
    end else begin
      cols_eff = ECOL_W'(grid_cols);
    end
  end

  // Handshake: the read stage moves on whenever the output register is
  // empty or its result is being taken. A pending register write keeps new
  // requests out until it has been taken.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !cfg_valid && (!s1_valid || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Position of the sample being taken, and the position after it.
  always_comb begin
    r_cur = ({1'b0, row_cnt} >= rows_eff) ? '0 : row_cnt;
    c_cur = ({1'b0, col_cnt} >= cols_eff) ? '0 : col_cnt;
    r_inc = {1'b0, r_cur} + ROWS_W'(1);
    c_inc = {1'b0, c_cur} + ECOL_W'(1);
    row_next = r_cur;
    col_next = c_inc[CNT_W-1:0];
    if (c_inc >= cols_eff) begin
      col_next = '0;
      row_next = (r_inc >= rows_eff) ? '0 : r_inc[ROW_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (cfg_restart) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      row_cnt <= row_next;
      col_cnt <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= elevation;
      s1_idx   <= c_cur;
      s1_first <= (r_cur == '0) && (c_cur == '0);
      s1_win   <= (32'(r_cur) >= 32'd2) && (32'(c_cur) >= 32'd2);
      s1_last  <= ({1'b0, r_cur} == rows_eff - ROWS_W'(1)) &&
                  ({1'b0, c_cur} == cols_eff - ECOL_W'(1));
    end
  end

  // The upper half of a word holds the upper row, the lower half the middle
  // row. As a sample leaves the read stage, its middle row entry moves up
  // and the sample itself becomes the middle row entry.
  gpc_line_store #(
    .DEPTH  (MAX_COLS),
    .DATA_W (2*SW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_idx),
    .wr_data ({rd_mid, s1_x}),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (rd_word)
  );

  assign rd_upper = rd_word[2*SW-1:SW];
  assign rd_mid   = rd_word[SW-1:0];
  assign new_col  = {s1_x, rd_mid, rd_upper};

  // Cell b holds the window's center column, cell a its left column; the
  // right column is the one in the read stage. Each advance shifts by one.
  assign centre = col_b[1];

  gpc_column_cell #(
    .SAMPLE_WIDTH (SW)
  ) u_cell_a (
    .clk    (clk),
    .shift  (advance),
    .col_in (col_b),
    .centre (centre),
    .col_q  (col_a),
    .below  (below_a)
  );

  gpc_column_cell #(
    .SAMPLE_WIDTH (SW)
  ) u_cell_b (
    .clk    (clk),
    .shift  (advance),
    .col_in (new_col),
    .centre (centre),
    .col_q  (col_b),
    .below  (below_b)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      below_new[k] = $signed(new_col[k]) < $signed(centre);
    end
  end

  // The center itself is skipped in cell b.
  assign peak = s1_win && (&below_a) && below_b[0] && below_b[2] && (&below_new);

  always_comb begin
    if (s1_first) begin
      peak_total_next = '0;
    end else if (peak && (peak_total != '1)) begin
      peak_total_next = peak_total + COUNT_W'(1);
    end else begin
      peak_total_next = peak_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_total <= '0;
    end else if (cfg_restart) begin
      peak_total <= '0;
    end else if (advance) begin
      peak_total <= peak_total_next;
    end
  end

  // Output register. The running count only changes as a result is loaded
  // or on a restart, so it is shown directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      window_valid <= s1_win;
      is_peak      <= peak;
      frame_last   <= s1_last;
    end
  end

  assign peak_count = peak_total;

endmodule

`default_nettype wire
